### hdl/vfr_pkg.sv
// Shared types and constants for the vertex first-use remap block.
// Depends on nothing; imported by the top level.
package vfr_pkg;

    // Fixed widths of the transaction fields.
    localparam int unsigned INDEX_W  = 32;
    localparam int unsigned NEW_W    = 12;
    localparam int unsigned ORIG_W   = 12;
    localparam int unsigned COUNT_W  = 13;
    localparam int unsigned VCOUNT_W = 13;

    // Reset value of the vertex count register.
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 13'd4096;

    // Width of the mesh tag stored with each table entry.
    localparam int unsigned EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'd255;
    localparam logic [EPOCH_W-1:0] EPOCH_STALE = 8'd0;

    // One result transaction.
    typedef struct packed {
        logic [NEW_W-1:0]   new_index;
        logic               first_seen;
        logic [ORIG_W-1:0]  original_index;
        logic               out_of_range;
        logic [COUNT_W-1:0] distinct_count;
    } t_result;

endpackage

### hdl/vertex_first_use_remap_top.sv
// Top level of the vertex first-use remap block: input register, table lookup,
// result buffer. Depends on vfr_pkg and vfr_ram.
//
//  Port group        Direction  Handshake                  Payload
//  input channel     in         i_in_valid / o_in_ready     i_vertex_index, i_last_of_mesh
//  result channel    out        o_out_valid / i_out_ready   o_new_index .. o_distinct_count
//  configuration     in         i_cfg_we                    i_cfg_wdata (vertex count)
//
// One transaction is accepted per cycle in steady flow; a result waits on the
// registered table read in the lookup stage and is then stored in the result buffer.
// After reset a clearing pass sweeps all MAX_VERTICES table entries; no input
// is taken meanwhile. Each mesh end advances an 8-bit mesh tag, and every 255th
// mesh end runs the same clearing pass.
// The result buffer holds two transactions, so a stalled output stops input only
// once two transactions are in flight.
module vertex_first_use_remap_top
    import vfr_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [VCOUNT_W-1:0]  i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [INDEX_W-1:0]   i_vertex_index,
    input  logic                 i_last_of_mesh,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [NEW_W-1:0]     o_new_index,
    output logic                 o_first_seen,
    output logic [ORIG_W-1:0]    o_original_index,
    output logic                 o_out_of_range,
    output logic [COUNT_W-1:0]   o_distinct_count
);

    localparam int unsigned AW    = $clog2(MAX_VERTICES);
    localparam int unsigned CW    = $clog2(MAX_VERTICES + 1);
    localparam int unsigned RAM_W = EPOCH_W + AW;

    // Configuration and mesh bookkeeping.
    logic [VCOUNT_W-1:0] r_vcount;
    logic [CW-1:0]       r_next;
    logic [CW-1:0]       n_next;
    logic [EPOCH_W-1:0]  r_epoch;
    logic                r_clr_active;
    logic [AW-1:0]       r_clr_addr;

    // Lookup stage registers.
    logic          r_s1_valid;
    logic [AW-1:0] r_s1_slot;
    logic          r_s1_inrange;
    logic          r_s1_last;
    logic          r_s1_fwd;
    logic [AW-1:0] r_s1_fwd_num;

    // Result buffer.
    t_result r_buf [2];
    logic    r_wr_ptr;
    logic    r_rd_ptr;
    logic [1:0] r_cnt;

    // Handshake and datapath signals.
    logic             in_acc;
    logic             out_pop;
    logic             in_range;
    logic [AW-1:0]    in_slot;
    logic [2:0]       occ;
    logic             wrap_block;
    logic [RAM_W-1:0] ram_rdata;
    logic [RAM_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_waddr;
    logic             ram_we;
    logic             s1_seen;
    logic             s1_first;
    logic [AW-1:0]    s1_old_num;
    logic [AW-1:0]    s1_number;
    logic             fwd_hit;
    logic             clr_done;
    t_result          s1_result;

    // Range check against the smaller of the vertex count and the table size.
    assign in_range = (i_vertex_index < INDEX_W'(r_vcount))
                   && (i_vertex_index < INDEX_W'(MAX_VERTICES));
    assign in_slot  = i_vertex_index[AW-1:0];

    // Input waits while two transactions stay in flight or a clearing pass runs or is due.
    assign out_pop    = o_out_valid && i_out_ready;
    assign occ        = {1'b0, r_cnt} + {2'b00, r_s1_valid};
    assign wrap_block = r_s1_valid && r_s1_last && (r_epoch == EPOCH_LAST);
    assign o_in_ready = !r_clr_active && !wrap_block
                     && ((occ < 3'd2) || ((occ == 3'd2) && out_pop));
    assign in_acc     = i_in_valid && o_in_ready;

    // Lookup stage: an entry counts as seen when it carries this mesh's tag or is forwarded.
    assign s1_seen    = r_s1_fwd || (ram_rdata[RAM_W-1 -: EPOCH_W] == r_epoch);
    assign s1_old_num = r_s1_fwd ? r_s1_fwd_num : ram_rdata[AW-1:0];
    assign s1_first   = r_s1_inrange && !s1_seen;
    assign s1_number  = s1_first ? r_next[AW-1:0] : s1_old_num;
    assign n_next     = r_next + CW'(s1_first);

    // A write in flight to the slot being read now is forwarded past the RAM.
    assign fwd_hit = r_s1_valid && s1_first && !r_s1_last && in_range
                  && (r_s1_slot == in_slot);

    // Result of the lookup stage.
    always_comb begin
        s1_result.new_index      = r_s1_inrange ? NEW_W'(s1_number) : '0;
        s1_result.first_seen     = s1_first;
        s1_result.original_index = r_s1_inrange ? ORIG_W'(r_s1_slot) : '0;
        s1_result.out_of_range   = !r_s1_inrange;
        s1_result.distinct_count = COUNT_W'(n_next);
    end

    // Table write port: clearing pass or a first use.
    assign clr_done  = (r_clr_addr == AW'(MAX_VERTICES - 1));
    assign ram_we    = r_clr_active || (r_s1_valid && s1_first);
    assign ram_waddr = r_clr_active ? r_clr_addr : r_s1_slot;
    assign ram_wdata = r_clr_active ? {EPOCH_STALE, {AW{1'b0}}}
                                    : {r_epoch, r_next[AW-1:0]};

    vfr_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_VERTICES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (in_slot),
        .o_rdata (ram_rdata)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCOUNT_RESET;
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_wdata;
        end
    end

    // Counter, mesh tag and clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next       <= '0;
            r_epoch      <= EPOCH_FIRST;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else begin
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (clr_done) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (r_s1_valid) begin
                if (r_s1_last) begin
                    r_next <= '0;
                    if (r_epoch == EPOCH_LAST) begin
                        r_epoch      <= EPOCH_FIRST;
                        r_clr_active <= 1'b1;
                        r_clr_addr   <= '0;
                    end else begin
                        r_epoch <= r_epoch + EPOCH_W'(1);
                    end
                end else begin
                    r_next <= n_next;
                end
            end
        end
    end

    // Lookup stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
        end
    end

    // Lookup stage payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_slot    <= in_slot;
            r_s1_inrange <= in_range;
            r_s1_last    <= i_last_of_mesh;
            r_s1_fwd     <= fwd_hit;
            r_s1_fwd_num <= s1_number;
        end
    end

    // Result buffer pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (r_s1_valid) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (out_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= r_cnt + {1'b0, r_s1_valid} - {1'b0, out_pop};
        end
    end

    // Result buffer storage.
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_buf[r_wr_ptr] <= s1_result;
        end
    end

    assign o_out_valid      = (r_cnt != 2'd0);
    assign o_new_index      = r_buf[r_rd_ptr].new_index;
    assign o_first_seen     = r_buf[r_rd_ptr].first_seen;
    assign o_original_index = r_buf[r_rd_ptr].original_index;
    assign o_out_of_range   = r_buf[r_rd_ptr].out_of_range;
    assign o_distinct_count = r_buf[r_rd_ptr].distinct_count;

    // The result buffer never holds more than two transactions.
    a_buf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer overflow");

    // No input transaction is taken during a clearing pass.
    a_clr_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !o_in_ready)
        else $error("input accepted during clearing pass");

    // The live mesh tag never equals the tag written by the clearing pass.
    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != EPOCH_STALE)
        else $error("mesh tag matches cleared entries");

    // A mesh end in the lookup stage resets the counter on the next cycle.
    a_mesh_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |=> (r_next == '0))
        else $error("counter not cleared after mesh end");

endmodule

### hdl/vfr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used by the top level for the vertex table.
module vfr_ram #(
    parameter int unsigned WIDTH = 20,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
